### rtl/union_find_rank_compress_defines.svh
// Assertion macros used by the checker of the disjoint-set engine.
`ifndef UNION_FIND_RANK_COMPRESS_DEFINES_SVH
`define UNION_FIND_RANK_COMPRESS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UFRC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define UFRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

### rtl/ufrc_pkg.sv
// Shared constants and types of the disjoint-set engine.
`default_nettype none

package ufrc_pkg;

  // Node count and table widths
  localparam int NODES       = 1024;
  localparam int IDX_W       = $clog2(NODES);
  localparam int RANK_W      = 4;
  localparam int IN_TDATA_W  = ((2 * IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * IDX_W + 7) / 8) * 8;

  typedef logic [IDX_W-1:0]  node_t;
  typedef logic [RANK_W-1:0] rank_t;

  localparam rank_t RANK_MAX = {RANK_W{1'b1}};

  // Command codes
  localparam logic CMD_FIND  = 1'b0;
  localparam logic CMD_UNION = 1'b1;

  // Parent table port controls
  typedef struct packed {
    node_t rd_addr;
    logic  we;
    node_t wr_addr;
    node_t wr_data;
  } par_port_t;

  // Rank table port controls
  typedef struct packed {
    node_t rd_addr;
    logic  we;
    node_t wr_addr;
    rank_t wr_data;
  } rank_port_t;

endpackage

`default_nettype wire

### rtl/ufrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ufrc_ram #(
  parameter  int DEPTH = 1024,
  parameter  int WIDTH = 8,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/ufrc_seq.sv
// Sequencer: clearing pass, chain walk, path compression and rank link.
`default_nettype none

module ufrc_seq import ufrc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  wire logic  in_cmd,
  input  wire node_t in_node_a,
  input  wire node_t in_node_b,
  output logic       out_tvalid,
  input  wire logic  out_tready,
  output node_t      out_root_a,
  output node_t      out_root_b,
  output logic       out_merged,
  output par_port_t  par_o,
  input  wire node_t par_rd_data,
  output rank_port_t rank_o,
  input  wire rank_t rank_rd_data
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK,
    ST_COMP_RD,
    ST_COMP,
    ST_RANK_A,
    ST_RANK_B,
    ST_LINK,
    ST_DONE
  } state_t;

  localparam node_t LAST_NODE = node_t'(NODES - 1);

  state_t state_r, state_nxt;
  node_t  clr_cnt_r, clr_cnt_nxt;
  logic   cmd_r, cmd_nxt;
  node_t  node_a_r, node_a_nxt;
  node_t  node_b_r, node_b_nxt;
  logic   phase_b_r, phase_b_nxt;
  node_t  cur_r, cur_nxt;
  node_t  root_r, root_nxt;
  node_t  ra_r, ra_nxt;
  rank_t  rank_a_r, rank_a_nxt;
  logic   merged_r, merged_nxt;
  logic   out_valid_r, out_valid_nxt;
  node_t  out_root_a_r, out_root_a_nxt;
  node_t  out_root_b_r, out_root_b_nxt;
  logic   out_merged_r, out_merged_nxt;

  // Shared node comparator
  node_t cmp_x, cmp_y;
  logic  cmp_eq;
  logic  find_done;

  assign cmp_eq = (cmp_x == cmp_y);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    cmd_nxt        = cmd_r;
    node_a_nxt     = node_a_r;
    node_b_nxt     = node_b_r;
    phase_b_nxt    = phase_b_r;
    cur_nxt        = cur_r;
    root_nxt       = root_r;
    ra_nxt         = ra_r;
    rank_a_nxt     = rank_a_r;
    merged_nxt     = merged_r;
    out_root_a_nxt = out_root_a_r;
    out_root_b_nxt = out_root_b_r;
    out_merged_nxt = out_merged_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    par_o          = '0;
    par_o.rd_addr  = cur_r;
    rank_o         = '0;
    rank_o.rd_addr = ra_r;
    cmp_x          = cur_r;
    cmp_y          = root_r;
    find_done      = 1'b0;

    case (state_r)
      // Sweep both tables back to the reset forest
      ST_CLEAR: begin
        par_o.we       = 1'b1;
        par_o.wr_addr  = clr_cnt_r;
        par_o.wr_data  = clr_cnt_r;
        rank_o.we      = 1'b1;
        rank_o.wr_addr = clr_cnt_r;
        rank_o.wr_data = '0;
        clr_cnt_nxt    = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt     = in_cmd;
          node_a_nxt  = in_node_a;
          node_b_nxt  = in_node_b;
          cur_nxt     = in_node_a;
          phase_b_nxt = 1'b0;
          merged_nxt  = 1'b0;
          state_nxt   = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK;
      end
      // One parent hop per cycle until a node points at itself
      ST_WALK: begin
        cmp_x         = par_rd_data;
        cmp_y         = cur_r;
        par_o.rd_addr = par_rd_data;
        if (cmp_eq) begin
          root_nxt  = cur_r;
          cur_nxt   = phase_b_r ? node_b_r : node_a_r;
          state_nxt = ST_COMP_RD;
        end else begin
          cur_nxt = par_rd_data;
        end
      end
      // Start node already the root: nothing to compress; else go on to compress
      ST_COMP_RD: begin
        if (cmp_eq) begin
          find_done = 1'b1;
        end else begin
          state_nxt = ST_COMP;
        end
      end
      // Repoint the visited node at the root, fetch its old parent
      ST_COMP: begin
        par_o.we      = 1'b1;
        par_o.wr_addr = cur_r;
        par_o.wr_data = root_r;
        cmp_x         = par_rd_data;
        par_o.rd_addr = par_rd_data;
        if (cmp_eq) begin
          find_done = 1'b1;
        end else begin
          cur_nxt = par_rd_data;
        end
      end
      // Same set: no link; else go on to read the ranks
      ST_RANK_A: begin
        cmp_x = ra_r;
        if (cmp_eq) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_RANK_B;
        end
      end
      ST_RANK_B: begin
        rank_a_nxt     = rank_rd_data;
        rank_o.rd_addr = root_r;
        state_nxt      = ST_LINK;
      end
      // Link lower rank under higher; ties go under the second root
      ST_LINK: begin
        par_o.we = 1'b1;
        if (rank_rd_data < rank_a_r) begin
          par_o.wr_addr = root_r;
          par_o.wr_data = ra_r;
        end else begin
          par_o.wr_addr = ra_r;
          par_o.wr_data = root_r;
          if (rank_rd_data == rank_a_r && rank_rd_data != RANK_MAX) begin
            rank_o.we      = 1'b1;
            rank_o.wr_addr = root_r;
            rank_o.wr_data = rank_t'(rank_rd_data + 1'b1);
          end
        end
        merged_nxt = 1'b1;
        state_nxt  = ST_DONE;
      end
      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_root_a_nxt = ra_r;
          out_root_b_nxt = (cmd_r == CMD_UNION) ? root_r : '0;
          out_merged_nxt = merged_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // End of one find: move on to the second operand, the link or, for a find, the hand-off
    if (find_done) begin
      if (!phase_b_r) begin
        ra_nxt = root_r;
        if (cmd_r == CMD_UNION) begin
          phase_b_nxt = 1'b1;
          cur_nxt     = node_b_r;
          state_nxt   = ST_WALK_RD;
        end else begin
          state_nxt = ST_DONE;
        end
      end else begin
        state_nxt = ST_RANK_A;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    node_a_r     <= node_a_nxt;
    node_b_r     <= node_b_nxt;
    phase_b_r    <= phase_b_nxt;
    cur_r        <= cur_nxt;
    root_r       <= root_nxt;
    ra_r         <= ra_nxt;
    rank_a_r     <= rank_a_nxt;
    merged_r     <= merged_nxt;
    out_root_a_r <= out_root_a_nxt;
    out_root_b_r <= out_root_b_nxt;
    out_merged_r <= out_merged_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_root_a = out_root_a_r;
  assign out_root_b = out_root_b_r;
  assign out_merged = out_merged_r;

endmodule

`default_nettype wire

### rtl/union_find_rank_compress.sv
// Disjoint-set engine top level: union by rank with path compression.
//
// Input channel (in_*): one item per command. in_tuser is the command
// (0 = find node_a, 1 = union node_a with node_b); in_tdata carries the nodes.
// Output channel (out_*): exactly one result item per command, holding the
// root of node_a, the root of node_b (zero for find) and the merged flag.
// Items are worked one at a time; in_tready is high only while idle.
// A find walks the chain up to the root, then compresses the visited
// path, then loads the output register. A union runs two finds back to
// back, then, if the roots differ, reads the ranks and links them. The
// walk rate is set by the single read port of the parent table: one hop
// per cycle.
// After reset the tables are swept back to the initial forest, one entry a
// cycle, with in_tready low.
// A result waits in the output register while out_tready is low; the next
// item is still taken and worked, and stalls only at its hand-off.
`default_nettype none

module union_find_rank_compress import ufrc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // node_a, node_b, zero pad
  input  wire logic                   in_tuser,   // cmd
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // root_a, root_b, zero pad
  output logic                        out_tuser   // merged
);

  par_port_t  par_ctl;
  rank_port_t rank_ctl;
  node_t      par_rd_data;
  rank_t      rank_rd_data;
  node_t      root_a;
  node_t      root_b;

  ufrc_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_cmd       (in_tuser),
    .in_node_a    (in_tdata[IDX_W-1:0]),
    .in_node_b    (in_tdata[2*IDX_W-1:IDX_W]),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_root_a   (root_a),
    .out_root_b   (root_b),
    .out_merged   (out_tuser),
    .par_o        (par_ctl),
    .par_rd_data  (par_rd_data),
    .rank_o       (rank_ctl),
    .rank_rd_data (rank_rd_data)
  );

  // Parent table
  ufrc_ram #(.DEPTH(NODES), .WIDTH(IDX_W)) u_parent (
    .clk     (clk),
    .rd_addr (par_ctl.rd_addr),
    .rd_data (par_rd_data),
    .we      (par_ctl.we),
    .wr_addr (par_ctl.wr_addr),
    .wr_data (par_ctl.wr_data)
  );

  // Rank table
  ufrc_ram #(.DEPTH(NODES), .WIDTH(RANK_W)) u_rank (
    .clk     (clk),
    .rd_addr (rank_ctl.rd_addr),
    .rd_data (rank_rd_data),
    .we      (rank_ctl.we),
    .wr_addr (rank_ctl.wr_addr),
    .wr_data (rank_ctl.wr_data)
  );

  assign out_tdata = OUT_TDATA_W'({root_b, root_a});

endmodule

`default_nettype wire

### rtl/ufrc_checker.sv
// Port-level checker for the disjoint-set engine, bound to the top level.
`default_nettype none
`include "union_find_rank_compress_defines.svh"

module ufrc_checker import ufrc_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // Result held back by the receiver, and the two roots it shows
  logic  out_stall;
  node_t out_root_a;
  node_t out_root_b;

  assign out_stall  = out_tvalid && !out_tready;
  assign out_root_a = out_tdata[IDX_W-1:0];
  assign out_root_b = out_tdata[2*IDX_W-1:IDX_W];

  // Stalled result holds
  `UFRC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid)
  `UFRC_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall, $stable({out_tdata, out_tuser}))

  // A merge always joins two distinct roots
  `UFRC_ASSERT_IMPLY(a_merge_roots, clk, rst_n, out_tvalid && out_tuser, out_root_a != out_root_b)

  // Busy right after taking an item
  `UFRC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Clearing pass follows reset: nothing taken or shown
  `UFRC_ASSERT_IMPLY(a_clear_after_reset, clk, rst_n, !$past(rst_n), !in_tready && !out_tvalid)

endmodule

bind union_find_rank_compress ufrc_checker u_chk (.*);

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for the disjoint-set engine: union by rank with path compression.
module testbench;
  import ufrc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AFTER   = 400;
  localparam int PAD_W        = IN_TDATA_W - 2 * IDX_W;
  localparam int MAX_PRINTED  = 100;

  // One expected result item
  typedef struct packed {
    node_t root_a;
    node_t root_b;
    logic  merged;
  } root_result_t;

  // Forest mirror plus the queue of roots still owed by the block
  class dsu_scoreboard;
    node_t        parent_of[NODES];
    rank_t        rank_of[NODES];
    root_result_t expected_roots[$];
    int           n_errors;
    int           n_checked;

    function new();
      for (int i = 0; i < NODES; i++) begin
        parent_of[i] = node_t'(i);
        rank_of[i]   = '0;
      end
      n_errors  = 0;
      n_checked = 0;
    endfunction

    // Walk up to the root, then repoint the visited nodes at it
    function node_t find_and_compress(node_t n);
      node_t root = n;
      node_t cur  = n;
      node_t nxt;
      int    steps = 0;
      while (parent_of[root] != root && steps < NODES) begin
        root = parent_of[root];
        steps++;
      end
      steps = 0;
      while (cur != root && steps < NODES) begin
        nxt            = parent_of[cur];
        parent_of[cur] = root;
        cur            = nxt;
        steps++;
      end
      return root;
    endfunction

    // Apply one accepted command and queue the roots it must report
    function void note_command(logic cmd, node_t a, node_t b);
      root_result_t res;
      res.root_a = find_and_compress(a);
      res.root_b = '0;
      res.merged = 1'b0;
      if (cmd == CMD_UNION) begin
        res.root_b = find_and_compress(b);
        if (res.root_a != res.root_b) begin
          // lower rank goes under higher; on a tie the first root goes under
          if (rank_of[res.root_a] < rank_of[res.root_b]) begin
            parent_of[res.root_a] = res.root_b;
          end else if (rank_of[res.root_b] < rank_of[res.root_a]) begin
            parent_of[res.root_b] = res.root_a;
          end else begin
            parent_of[res.root_a] = res.root_b;
            if (rank_of[res.root_b] != RANK_MAX)
              rank_of[res.root_b] = rank_of[res.root_b] + 1'b1;
          end
          res.merged = 1'b1;
        end
      end
      expected_roots.insert(expected_roots.size(), res);
    endfunction

    function int pending();
      return expected_roots.size();
    endfunction

    task report(string what);
      n_errors++;
      // keep the log bounded once state has gone wrong
      if (n_errors <= MAX_PRINTED)
        $display("mismatch, result %0d: %s", n_checked, what);
    endtask

    // Compare one result item with the oldest expectation
    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic merged);
      root_result_t want;
      if (expected_roots.size() == 0) begin
        report($sformatf("unexpected result tdata=%h merged=%b", tdata, merged));
        return;
      end
      want = expected_roots.pop_front();
      n_checked++;
      if (tdata[IDX_W-1:0] !== want.root_a)
        report($sformatf("root_a %0d, want %0d", tdata[IDX_W-1:0], want.root_a));
      if (tdata[2*IDX_W-1:IDX_W] !== want.root_b)
        report($sformatf("root_b %0d, want %0d", tdata[2*IDX_W-1:IDX_W], want.root_b));
      if (merged !== want.merged)
        report($sformatf("merged %b, want %b", merged, want.merged));
      if (tdata[OUT_TDATA_W-1:2*IDX_W] !== '0)
        report($sformatf("pad bits %b not zero", tdata[OUT_TDATA_W-1:2*IDX_W]));
    endtask
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // node_a, node_b, zero pad
  logic                   in_tuser   = 1'b0;  // cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // root_a, root_b, zero pad
  logic                   out_tuser;  // merged

  dsu_scoreboard sb = new();
  int            n_accepted     = 0;
  int            burst_left     = 0;
  int            cycle_count    = 0;
  bit            long_hold_done = 1'b0;

  union_find_rank_compress u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // Offer one command, wait for the handshake, then maybe pause
  task automatic offer(input logic cmd, input node_t a, input node_t b);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{PAD_W{1'b0}}, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(cmd, a, b);
    n_accepted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      // mostly short bursts, now and then a long unbroken one
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  // Extremes, both link directions, tie on rank, same set and a deep path
  task automatic run_directed();
    offer(CMD_FIND,  10'd0,    10'd0);
    offer(CMD_FIND,  10'd1023, 10'd1023);
    offer(CMD_UNION, 10'd0,    10'd1023);
    offer(CMD_UNION, 10'd1023, 10'd0);
    offer(CMD_UNION, 10'd5,    10'd5);
    offer(CMD_FIND,  10'd0,    10'd1023);
    offer(CMD_UNION, 10'd1,    10'd2);
    offer(CMD_UNION, 10'd2,    10'd0);
    offer(CMD_FIND,  10'd1,    10'd0);
    offer(CMD_UNION, 10'd3,    10'd1023);
    offer(CMD_UNION, 10'd1023, 10'd4);
    offer(CMD_FIND,  10'd4,    10'd1023);
    offer(CMD_UNION, 10'd682,  10'd341);
    offer(CMD_UNION, 10'd10,   10'd11);
    offer(CMD_UNION, 10'd12,   10'd13);
    offer(CMD_UNION, 10'd11,   10'd13);
    offer(CMD_UNION, 10'd14,   10'd15);
    offer(CMD_UNION, 10'd16,   10'd17);
    offer(CMD_UNION, 10'd15,   10'd17);
    offer(CMD_UNION, 10'd13,   10'd17);
    offer(CMD_FIND,  10'd10,   10'd682);
    offer(CMD_UNION, 10'd12,   10'd341);
    offer(CMD_UNION, 10'd10,   10'd1);
    offer(CMD_FIND,  10'd341,  10'd0);
  endtask

  // Commands clustered in a moving window so sets grow deep; some full-range noise
  task automatic run_random(input int count);
    int    span;
    int    pick;
    node_t base;
    node_t a;
    node_t b;
    logic  cmd;
    span = 16;
    base = '0;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: span = 8;
          1: span = 32;
          2: span = 128;
          default: span = 512;
        endcase
        base = node_t'($urandom_range(0, NODES - span));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        cmd = logic'($urandom);
        a   = node_t'($urandom);
        b   = node_t'($urandom);
      end else begin
        cmd = (pick <= 6) ? CMD_UNION : CMD_FIND;
        a   = base + node_t'($urandom_range(0, span - 1));
        b   = base + node_t'($urandom_range(0, span - 1));
      end
      offer(cmd, a, b);
    end
  endtask

  // Receiver: segments of varying stall density, plus one long hold
  initial begin : receiver
    int seg_left;
    int stall_pct;
    seg_left  = 0;
    stall_pct = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!long_hold_done && n_accepted >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        seg_left--;
        out_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Reset, stimulus, drain and verdict
  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(1100);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### union_find_rank_compress.f
+incdir+rtl
rtl/ufrc_pkg.sv
rtl/ufrc_ram.sv
rtl/ufrc_seq.sv
rtl/union_find_rank_compress.sv
rtl/ufrc_checker.sv
tb/sv/testbench.sv
